@@ hw/rtl/kmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
        logic fix;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic start_walk;
        logic start_emit;
        logic walk_done;
        logic full_hit;
        logic is_text;
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/kmp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                           i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/kmp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmp_datapath #(
    parameter int PATTERN_MAX   = 1024,
    parameter int SYMBOL_BITS   = 8,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_kind,
    input  wire logic                     i_first,
    input  wire logic [SYMBOL_BITS-1:0]   i_symbol,
    input  wire kmp_pkg::t_cmd            i_cmd,
    output kmp_pkg::t_status              o_status,
    output logic                          o_match,
    output logic [POSITION_BITS-1:0]      o_match_start
);

    import kmp_pkg::*;

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int XW = (POSITION_BITS > LW) ? POSITION_BITS : LW;
    localparam logic [LW-1:0] CountMax = LW'(PATTERN_MAX);
    localparam logic [POSITION_BITS-1:0] PosMax = '1;

    logic [LW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_pcur, n_pcur;
    logic                     r_pcur_neg, n_pcur_neg;
    logic [AW-1:0]            r_mlen, n_mlen;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_pos_item, n_pos_item;
    logic                     r_kind, n_kind;
    logic [SYMBOL_BITS-1:0]   r_sym, n_sym;
    logic [AW-1:0]            r_k, n_k;
    logic                     r_kneg, n_kneg;
    logic                     r_hit, n_hit;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic                     r_o_match, n_o_match;
    logic [POSITION_BITS-1:0] r_o_start, n_o_start;

    logic                     pat_first;
    logic [LW-1:0]            count_eff;
    logic                     room;
    logic [POSITION_BITS-1:0] pos_item;
    logic [AW-1:0]            mlen_eff;
    logic                     mlen_ok;
    logic                     walk_done;
    logic [LW-1:0]            kp;
    logic                     full_hit;
    logic [LW-1:0]            back;
    logic [XW-1:0]            pos_x;
    logic [XW-1:0]            back_x;
    logic [POSITION_BITS-1:0] start_val;

    logic                     store_we;
    logic                     link_we;
    logic [AW-1:0]            link_raddr;
    logic [SYMBOL_BITS-1:0]   sym_rd;
    logic [AW-1:0]            link_rd;

    kmp_ram #(
        .WIDTH (SYMBOL_BITS),
        .DEPTH (PATTERN_MAX)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_we),
        .i_wr_addr (count_eff[AW-1:0]),
        .i_wr_data (i_symbol),
        .i_rd_addr (n_k),
        .o_rd_data (sym_rd)
    );

    kmp_ram #(
        .WIDTH (AW),
        .DEPTH (PATTERN_MAX)
    ) u_links (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (kp[AW-1:0]),
        .i_rd_addr (link_raddr),
        .o_rd_data (link_rd)
    );

    always_comb begin
        pat_first = (i_kind == KIND_PATTERN) && i_first;
        count_eff = pat_first ? '0 : r_count;
        room      = count_eff < CountMax;
        pos_item  = i_first ? '0 : r_pos;
        mlen_eff  = i_first ? '0 : r_mlen;
        mlen_ok   = LW'(mlen_eff) < r_count;
        walk_done = r_kneg || (sym_rd == r_sym);
        kp        = r_kneg ? '0 : LW'(r_k) + LW'(1);
        full_hit  = (r_kind == KIND_TEXT) && (kp == r_count);
        back      = r_count - LW'(1);
        pos_x     = XW'(r_pos_item);
        back_x    = XW'(back);
        start_val = (pos_x >= back_x) ? POSITION_BITS'(pos_x - back_x) : '0;

        n_count    = r_count;
        n_pcur     = r_pcur;
        n_pcur_neg = r_pcur_neg;
        n_mlen     = r_mlen;
        n_pos      = r_pos;
        n_pos_item = r_pos_item;
        n_kind     = r_kind;
        n_sym      = r_sym;
        n_k        = r_k;
        n_kneg     = r_kneg;
        n_hit      = r_hit;
        n_start    = r_start;
        n_o_match  = r_o_match;
        n_o_start  = r_o_start;
        store_we   = 1'b0;
        link_we    = 1'b0;

        if (i_cmd.start) begin
            n_kind = i_kind;
            n_sym  = i_symbol;
            if (i_kind == KIND_PATTERN) begin
                if (i_first) begin
                    n_count    = '0;
                    n_pcur_neg = 1'b1;
                    n_mlen     = '0;
                end
                store_we = room;
                n_k      = r_pcur;
                n_kneg   = i_first || r_pcur_neg || (LW'(r_pcur) >= count_eff);
            end else begin
                if (i_first) begin
                    n_mlen = '0;
                end
                n_pos      = (pos_item == PosMax) ? pos_item : pos_item + POSITION_BITS'(1);
                n_pos_item = pos_item;
                n_k        = mlen_ok ? mlen_eff : '0;
                n_kneg     = 1'b0;
                n_hit      = 1'b0;
                n_start    = '0;
            end
        end else if (i_cmd.step) begin
            if (!walk_done) begin
                n_kneg = (r_k == '0);
                n_k    = link_rd;
            end else if (r_kind == KIND_PATTERN) begin
                link_we    = 1'b1;
                n_count    = r_count + LW'(1);
                n_pcur     = kp[AW-1:0];
                n_pcur_neg = 1'b0;
            end else begin
                n_hit   = full_hit;
                n_start = full_hit ? start_val : '0;
                if (!full_hit) begin
                    n_mlen = kp[AW-1:0];
                end
            end
        end else if (i_cmd.fix) begin
            n_mlen = link_rd;
        end

        if (i_cmd.emit) begin
            n_o_match = r_hit;
            n_o_start = r_start;
        end

        link_raddr = (i_cmd.step && walk_done && (r_kind == KIND_TEXT)) ?
                     back[AW-1:0] : n_k - AW'(1);

        o_status.start_walk = (i_kind == KIND_PATTERN) ? room : (r_count != '0);
        o_status.start_emit = (i_kind == KIND_TEXT) && (r_count == '0);
        o_status.walk_done  = walk_done;
        o_status.full_hit   = full_hit;
        o_status.is_text    = (r_kind == KIND_TEXT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_pcur     <= '0;
            r_pcur_neg <= 1'b1;
            r_mlen     <= '0;
            r_pos      <= '0;
        end else begin
            r_count    <= n_count;
            r_pcur     <= n_pcur;
            r_pcur_neg <= n_pcur_neg;
            r_mlen     <= n_mlen;
            r_pos      <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_item <= n_pos_item;
        r_kind     <= n_kind;
        r_sym      <= n_sym;
        r_k        <= n_k;
        r_kneg     <= n_kneg;
        r_hit      <= n_hit;
        r_start    <= n_start;
        r_o_match  <= n_o_match;
        r_o_start  <= n_o_start;
    end

    assign o_match       = r_o_match;
    assign o_match_start = r_o_start;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountMax)
        else $error("pattern count beyond store size");

    a_mlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mlen == '0) || (LW'(r_mlen) < r_count))
        else $error("partial match not shorter than pattern");

    a_pcur_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcur_neg || (LW'(r_pcur) < r_count))
        else $error("prefix cursor outside stored pattern");

    a_walk_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !r_kneg) |-> (LW'(r_k) < r_count))
        else $error("walk cursor outside stored pattern");

endmodule

`default_nettype wire

@@ hw/rtl/kmp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kmp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire kmp_pkg::t_status i_status,
    output kmp_pkg::t_cmd         o_cmd
);

    import kmp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_status.start_walk) begin
                        n_state = ST_WALK;
                    end else if (i_status.start_emit) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.walk_done) begin
                    if (i_status.full_hit) begin
                        n_state = ST_FIX;
                    end else if (i_status.is_text) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.emit || (r_out_valid && i_stall);
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hw/rtl/kmp_stream_matcher_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming Knuth-Morris-Pratt matcher: kind 0 appends a pattern symbol (first starts a new
// pattern), kind 1 searches a text symbol (first restarts the text) and returns one result
// with the match flag and the start position of the occurrence that ends there. One item is
// in work at a time. A pattern symbol takes a start step and then n failure-link steps, where
// n includes the final compare; a text symbol takes the same, then a fix step on a full match
// and an emit step. Each failure-link step is one read of the pattern and link RAMs. A pattern
// symbol beyond the store size is not stored and does no walk, and a text symbol against an
// empty pattern goes straight to its emit step. Failure steps average at most one per
// symbol. The result sits in an output register, so the next item is taken while it waits;
// a text symbol whose result is ready while the previous one still waits holds there until
// the output is taken. Both RAMs come up unwritten and need no clearing pass after reset.
module kmp_stream_matcher_core #(
    parameter int PATTERN_MAX   = 1024,
    parameter int SYMBOL_BITS   = 8,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic                     i_kind,
    input  wire logic                     i_first,
    input  wire logic [SYMBOL_BITS-1:0]   i_symbol,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_match,
    output logic [POSITION_BITS-1:0]      o_match_start
);

    import kmp_pkg::*;

    t_cmd    cmd;
    t_status status;

    kmp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    kmp_datapath #(
        .PATTERN_MAX   (PATTERN_MAX),
        .SYMBOL_BITS   (SYMBOL_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_kind        (i_kind),
        .i_first       (i_first),
        .i_symbol      (i_symbol),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_match       (o_match),
        .o_match_start (o_match_start)
    );

endmodule

`default_nettype wire
